// ----- src/display_packet_framer_deframer_assert.svh -----
// Assertion helpers for the verification files of the display packet engine.
`ifndef DISPLAY_PACKET_FRAMER_DEFRAMER_ASSERT_SVH
`define DISPLAY_PACKET_FRAMER_DEFRAMER_ASSERT_SVH

// Check a property on the rising clock edge, disabled while reset is asserted.
`define PFD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("display packet engine assertion failed");

// Check a property on the rising clock edge, also during reset.
`define PFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("display packet engine assertion failed");

`endif

// ----- src/pfd_pkg.sv -----
package pfd_pkg;

    // Default depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Stream widths.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    // Link bytes.
    localparam logic [7:0] BYTE_ACK      = 8'h06;
    localparam logic [7:0] BYTE_DC1      = 8'h11;
    localparam logic [7:0] BYTE_DC2      = 8'h12;
    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_READ_LEN = 8'h01;
    localparam logic [7:0] BYTE_READ_CMD = 8'h53;
    localparam logic [7:0] BYTE_DUMMY    = 8'h00;
    localparam logic [7:0] READ_SUM      = BYTE_DC2 + BYTE_READ_LEN + BYTE_READ_CMD;

    // Byte positions inside a framed transmission.
    localparam logic [2:0] STEP_FIRST     = 3'd0;
    localparam logic [2:0] STEP_PAYLOAD   = 3'd3;
    localparam logic [2:0] STEP_LAST_READ = 3'd4;
    localparam logic [2:0] STEP_LAST_CMD  = 3'd5;

    typedef enum logic [1:0] {
        REQ_PAYLOAD = 2'd0,
        REQ_READ    = 2'd1,
        REQ_RX      = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_ACKED    = 3'd0,
        ST_NO_ACK   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_READ_NAK = 3'd3,
        ST_NO_DC1   = 3'd4,
        ST_BAD_SUM  = 3'd5,
        ST_READ_OK  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CMD  = 3'd1,
        PH_ACK  = 3'd2,
        PH_DC1  = 3'd3,
        PH_LEN  = 3'd4,
        PH_DATA = 3'd5,
        PH_SUM  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        JOB_CMD     = 2'd0,
        JOB_READ    = 2'd1,
        JOB_RX_DATA = 2'd2,
        JOB_STATUS  = 2'd3
    } job_op_t;

    // One classified transaction, expanded into results by the back end.
    typedef struct packed {
        job_op_t    op;
        logic       head;
        logic       tail;
        logic [7:0] count;
        logic [7:0] data;
        logic [7:0] sum;
        status_t    status;
        logic [7:0] length;
    } job_t;

endpackage

// ----- src/pfd_front.sv -----
module pfd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [pfd_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          q_push,
    output pfd_pkg::job_t                 q_job
);

    pfd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      tx_sum_reg, tx_sum_next;
    logic [7:0]      rx_sum_reg, rx_sum_next;
    logic [7:0]      bytes_left_reg, bytes_left_next;
    logic [7:0]      reply_len_reg, reply_len_next;
    logic            reading_reg, reading_next;

    logic            accept;
    pfd_pkg::req_t   req;
    logic [7:0]      din;
    logic [7:0]      cnt_plus;
    logic            first_mark;
    logic            ready_mark;
    logic            start;
    logic [7:0]      base_sum;
    logic [7:0]      frame_sum;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && !q_full;
    assign req        = pfd_pkg::req_t'(s_tuser[1:0]);
    assign first_mark = s_tuser[2];
    assign din        = s_tdata[7:0];
    assign cnt_plus   = s_tdata[15:8] + 8'd1;
    assign ready_mark = s_tdata[16];
    assign start      = (phase_reg == pfd_pkg::PH_IDLE) && first_mark;
    assign base_sum   = start ? (pfd_pkg::BYTE_DC1 + cnt_plus + pfd_pkg::BYTE_ESC) : tx_sum_reg;
    assign frame_sum  = base_sum + din;

    // Classify the transaction, update link state, build the job
    always_comb begin
        phase_next      = phase_reg;
        tx_sum_next     = tx_sum_reg;
        rx_sum_next     = rx_sum_reg;
        bytes_left_next = bytes_left_reg;
        reply_len_next  = reply_len_reg;
        reading_next    = reading_reg;
        q_push          = 1'b0;
        q_job           = '0;
        q_job.count     = cnt_plus;
        q_job.data      = din;
        q_job.sum       = frame_sum;
        q_job.head      = start;
        q_job.tail      = s_tlast;
        if (accept) begin
            case (req)
                pfd_pkg::REQ_PAYLOAD: begin
                    if (start || phase_reg == pfd_pkg::PH_CMD) begin
                        q_push      = 1'b1;
                        q_job.op    = pfd_pkg::JOB_CMD;
                        tx_sum_next = frame_sum;
                        if (s_tlast) begin
                            phase_next   = pfd_pkg::PH_ACK;
                            reading_next = 1'b0;
                        end else begin
                            phase_next = pfd_pkg::PH_CMD;
                        end
                    end
                end
                pfd_pkg::REQ_READ: begin
                    if (phase_reg == pfd_pkg::PH_IDLE) begin
                        q_push = 1'b1;
                        if (!ready_mark) begin
                            q_job.op     = pfd_pkg::JOB_STATUS;
                            q_job.status = pfd_pkg::ST_EMPTY;
                            reading_next = 1'b0;
                        end else begin
                            q_job.op     = pfd_pkg::JOB_READ;
                            tx_sum_next  = pfd_pkg::READ_SUM;
                            phase_next   = pfd_pkg::PH_ACK;
                            reading_next = 1'b1;
                        end
                    end
                end
                pfd_pkg::REQ_RX: begin
                    case (phase_reg)
                        pfd_pkg::PH_ACK: begin
                            if (din != pfd_pkg::BYTE_ACK) begin
                                q_push       = 1'b1;
                                q_job.op     = pfd_pkg::JOB_STATUS;
                                q_job.status = reading_reg ? pfd_pkg::ST_READ_NAK
                                                           : pfd_pkg::ST_NO_ACK;
                                phase_next   = pfd_pkg::PH_IDLE;
                                reading_next = 1'b0;
                            end else if (!reading_reg) begin
                                q_push       = 1'b1;
                                q_job.op     = pfd_pkg::JOB_STATUS;
                                q_job.status = pfd_pkg::ST_ACKED;
                                phase_next   = pfd_pkg::PH_IDLE;
                            end else begin
                                phase_next = pfd_pkg::PH_DC1;
                            end
                        end
                        pfd_pkg::PH_DC1: begin
                            if (din != pfd_pkg::BYTE_DC1) begin
                                q_push       = 1'b1;
                                q_job.op     = pfd_pkg::JOB_STATUS;
                                q_job.status = pfd_pkg::ST_NO_DC1;
                                phase_next   = pfd_pkg::PH_IDLE;
                                reading_next = 1'b0;
                            end else begin
                                phase_next = pfd_pkg::PH_LEN;
                            end
                        end
                        pfd_pkg::PH_LEN: begin
                            reply_len_next  = din;
                            bytes_left_next = din;
                            rx_sum_next     = 8'd0;
                            phase_next      = (din == 8'd0) ? pfd_pkg::PH_SUM : pfd_pkg::PH_DATA;
                        end
                        pfd_pkg::PH_DATA: begin
                            q_push          = 1'b1;
                            q_job.op        = pfd_pkg::JOB_RX_DATA;
                            rx_sum_next     = rx_sum_reg + din;
                            bytes_left_next = bytes_left_reg - 8'd1;
                            if (bytes_left_reg == 8'd1) begin
                                phase_next = pfd_pkg::PH_SUM;
                            end
                        end
                        pfd_pkg::PH_SUM: begin
                            q_push       = 1'b1;
                            q_job.op     = pfd_pkg::JOB_STATUS;
                            if (din == rx_sum_reg) begin
                                q_job.status = pfd_pkg::ST_READ_OK;
                                q_job.length = reply_len_reg;
                            end else begin
                                q_job.status = pfd_pkg::ST_BAD_SUM;
                            end
                            phase_next   = pfd_pkg::PH_IDLE;
                            reading_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Hold link state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= pfd_pkg::PH_IDLE;
            tx_sum_reg     <= 8'd0;
            rx_sum_reg     <= 8'd0;
            bytes_left_reg <= 8'd0;
            reply_len_reg  <= 8'd0;
            reading_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            tx_sum_reg     <= tx_sum_next;
            rx_sum_reg     <= rx_sum_next;
            bytes_left_reg <= bytes_left_next;
            reply_len_reg  <= reply_len_next;
            reading_reg    <= reading_next;
        end
    end

endmodule

// ----- src/pfd_fifo.sv -----
module pfd_fifo #(
    parameter int DEPTH = pfd_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pfd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output pfd_pkg::job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfd_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- src/pfd_back.sv -----
module pfd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  pfd_pkg::job_t                 q_job,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [pfd_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    pfd_pkg::job_t                 job_reg, job_next;
    logic                          active_reg, active_next;
    logic [2:0]                    step_reg, step_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [pfd_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [pfd_pkg::M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                          m_tlast_reg, m_tlast_next;

    logic             out_free;
    logic             emit;
    logic [2:0]       last_step;
    logic             at_last;
    logic             tx_v, rx_v, st_v;
    logic [7:0]       tx_b, rx_b, len;
    pfd_pkg::status_t st;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = active_reg && out_free;
    assign at_last  = (step_reg == last_step);
    assign q_pop    = q_valid && (!active_reg || (emit && at_last));

    // Select the result for the current step of the job
    always_comb begin
        last_step = pfd_pkg::STEP_FIRST;
        tx_v      = 1'b0;
        rx_v      = 1'b0;
        st_v      = 1'b0;
        tx_b      = 8'd0;
        rx_b      = 8'd0;
        len       = 8'd0;
        st        = pfd_pkg::ST_ACKED;
        case (job_reg.op)
            pfd_pkg::JOB_CMD: begin
                last_step = job_reg.tail ? pfd_pkg::STEP_LAST_CMD : pfd_pkg::STEP_PAYLOAD;
                tx_v      = 1'b1;
                case (step_reg)
                    3'd0:    tx_b = pfd_pkg::BYTE_DC1;
                    3'd1:    tx_b = job_reg.count;
                    3'd2:    tx_b = pfd_pkg::BYTE_ESC;
                    3'd3:    tx_b = job_reg.data;
                    3'd4:    tx_b = job_reg.sum;
                    default: tx_b = pfd_pkg::BYTE_DUMMY;
                endcase
            end
            pfd_pkg::JOB_READ: begin
                last_step = pfd_pkg::STEP_LAST_READ;
                tx_v      = 1'b1;
                case (step_reg)
                    3'd0:    tx_b = pfd_pkg::BYTE_DC2;
                    3'd1:    tx_b = pfd_pkg::BYTE_READ_LEN;
                    3'd2:    tx_b = pfd_pkg::BYTE_READ_CMD;
                    3'd3:    tx_b = pfd_pkg::READ_SUM;
                    default: tx_b = pfd_pkg::BYTE_DUMMY;
                endcase
            end
            pfd_pkg::JOB_RX_DATA: begin
                rx_v = 1'b1;
                rx_b = job_reg.data;
            end
            pfd_pkg::JOB_STATUS: begin
                st_v = 1'b1;
                st   = job_reg.status;
                len  = job_reg.length;
            end
            default: begin
            end
        endcase
    end

    // Drive the output register and walk through the job
    always_comb begin
        job_next      = job_reg;
        active_next   = active_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'd0, len, st, rx_b, tx_b};
            m_tuser_next  = {st_v, rx_v, tx_v};
            m_tlast_next  = at_last;
            step_next     = step_reg + 3'd1;
            if (at_last) begin
                active_next = 1'b0;
            end
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (q_pop) begin
            job_next    = q_job;
            active_next = 1'b1;
            step_next   = (q_job.op == pfd_pkg::JOB_CMD && !q_job.head) ?
                          pfd_pkg::STEP_PAYLOAD : pfd_pkg::STEP_FIRST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            step_reg     <= pfd_pkg::STEP_FIRST;
            m_tvalid_reg <= 1'b0;
        end else begin
            active_reg   <= active_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        job_reg     <= job_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

// ----- src/display_packet_framer_deframer.sv -----
// Byte engine for a display link with additive-checksum framing.
// Slave stream s_*: one transaction per request. s_tuser[1:0] is the request kind
// (payload byte, read request, byte received from the bus), s_tuser[2] marks the
// first payload byte of a command, s_tlast the last one.
// Master stream m_*: one transaction per result. m_tuser tells whether it carries a
// byte to transmit, a received data byte or a closing status; m_tlast marks the
// last result caused by one request.
// A front end classifies each request and updates the link state in its cycle,
// then may queue one job; a back end expands each job into one to six results.
// An accepted request reaches its first result through the queue entry, the job
// register and the output register of the back end. Throughput: one result per
// cycle while m_tready is high (up to six results per request), set by the single
// output register of the back end. The job queue holds QUEUE_DEPTH jobs.
// Reset (aresetn low, synchronous) returns the link to idle and empties the queue.
// When m_tready is low the output holds, the queue fills and s_tready drops.
module display_packet_framer_deframer #(
    parameter int QUEUE_DEPTH = pfd_pkg::QUEUE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] data, [15:8] payload_count, [16] buffer_ready
    input  logic [pfd_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type, [2] first
    input  logic [pfd_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] tx_byte, [15:8] rx_byte, [18:16] status, [26:19] read_length
    output logic [pfd_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] tx_valid, [1] rx_valid, [2] status_valid
    output logic [pfd_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);

    logic          fr_push;
    pfd_pkg::job_t fr_job;
    logic          q_full;
    logic          q_valid;
    pfd_pkg::job_t q_job;
    logic          bk_pop;

    pfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (fr_push),
        .q_job    (fr_job)
    );

    pfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fr_push),
        .push_job  (fr_job),
        .full      (q_full),
        .pop       (bk_pop),
        .pop_valid (q_valid),
        .pop_job   (q_job)
    );

    pfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (bk_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- src/pfd_checker.sv -----
`include "display_packet_framer_deframer_assert.svh"

module pfd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [pfd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [pfd_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);

    // A stalled result holds its payload
    `PFD_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Each result is exactly one kind
    `PFD_ASSERT(a_one_kind, aclk, aresetn, m_tvalid |-> $onehot(m_tuser))

    // A status always closes the run of its request
    `PFD_ASSERT(a_status_last, aclk, aresetn, m_tvalid && m_tuser[2] |-> m_tlast)

    // No result right after reset
    `PFD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind display_packet_framer_deframer pfd_checker u_pfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
